FILE: rtl/rrpd_pkg.sv
// shared types, constants and product codes of the radial product decoder
package rrpd_pkg;

  localparam int HEADER_BYTES = 64;
  localparam int MAX_BINS     = 4096;

  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 13;   // width of a bin count register
  localparam int POS_W   = 16;   // byte position within a record
  localparam int BND_W   = 17;   // region boundaries within the record body
  localparam int BIN_W   = 12;
  localparam int CODE_W  = 16;
  localparam int VAL_W   = 24;
  localparam int PROD_W  = 3;
  localparam int ADDR_W  = 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // phidp rounding division by 2^15-1
  localparam int PH_W     = 36;  // halved numerator of the phidp rounding division
  localparam int PH_Q_W   = 21;
  localparam int PH_LOW_W = 15;
  localparam logic [PH_LOW_W-1:0] PH_DIV_M = 15'h7FFF;

  // register indexes of the configuration port
  localparam logic [ADDR_W-1:0] REG_REF_BINS = 1'd0;
  localparam logic [ADDR_W-1:0] REG_DPL_BINS = 1'd1;

  // product codes
  localparam logic [PROD_W-1:0] PROD_REF   = 3'd0;
  localparam logic [PROD_W-1:0] PROD_VEL   = 3'd1;
  localparam logic [PROD_W-1:0] PROD_WIDTH = 3'd2;
  localparam logic [PROD_W-1:0] PROD_ZDR   = 3'd3;
  localparam logic [PROD_W-1:0] PROD_RHOHV = 3'd4;
  localparam logic [PROD_W-1:0] PROD_KDP   = 3'd5;
  localparam logic [PROD_W-1:0] PROD_PHIDP = 3'd6;

  // top of the phidp code range, mapped to a fixed value
  localparam logic [CODE_W-1:0] PHIDP_TOP_CODE = 16'hFFFF;
  localparam logic [VAL_W-1:0]  PHIDP_TOP_VAL  = 24'd1474540;

  // one classified product sample on its way to the scaler
  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [BIN_W-1:0]  bin;
    logic [CODE_W-1:0] code;
    logic              last;
  } item_t;

  // region boundaries of the record body, relative to the end of the header
  typedef struct packed {
    logic [BND_W-1:0] vel_start;
    logic [BND_W-1:0] width_start;
    logic [BND_W-1:0] spare_start;
    logic [BND_W-1:0] zdr_start;
    logic [BND_W-1:0] rhohv_start;
    logic [BND_W-1:0] kdp_start;
    logic [BND_W-1:0] phidp_start;
    logic [BND_W-1:0] total;
  } bounds_t;

endpackage

FILE: rtl/rrpd_front.sv
// front end: bin count registers, record position counter and byte classifier
module rrpd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [rrpd_pkg::ADDR_W-1:0]         cfg_addr_i,
  input  logic [rrpd_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic                                accept_i,
  input  logic [rrpd_pkg::BYTE_W-1:0]         data_byte_i,
  input  logic                                first_byte_i,
  output logic                                emit_o,
  output rrpd_pkg::item_t                     item_o
);

  logic [rrpd_pkg::CNT_W-1:0]  ref_bins_q, ref_bins_d;
  logic [rrpd_pkg::CNT_W-1:0]  dpl_bins_q, dpl_bins_d;
  logic [rrpd_pkg::CNT_W-1:0]  cfg_sat;
  rrpd_pkg::bounds_t           bnd_q, bnd_d;
  logic [rrpd_pkg::BND_W-1:0]  r_ext, d_ext, rd2;
  logic [rrpd_pkg::POS_W-1:0]  pos_q, pos_d, pos;
  logic [rrpd_pkg::BYTE_W-1:0] held_q, held_d;
  logic [rrpd_pkg::BND_W-1:0]  p, base, off;
  logic                        in_header, in_body, is_phidp, emit;
  logic [rrpd_pkg::PROD_W-1:0] prod;

  assign cfg_sat = (cfg_data_i > rrpd_pkg::CNT_W'(rrpd_pkg::MAX_BINS))
                 ? rrpd_pkg::CNT_W'(rrpd_pkg::MAX_BINS) : cfg_data_i;

  always_comb begin
    ref_bins_d = ref_bins_q;
    dpl_bins_d = dpl_bins_q;
    if (cfg_valid_i) begin
      case (cfg_addr_i)
        rrpd_pkg::REG_REF_BINS: ref_bins_d = cfg_sat;
        rrpd_pkg::REG_DPL_BINS: dpl_bins_d = cfg_sat;
        default: ;
      endcase
    end
  end

  // boundaries follow the count registers on the same edge
  assign r_ext = rrpd_pkg::BND_W'(ref_bins_d);
  assign d_ext = rrpd_pkg::BND_W'(dpl_bins_d);
  assign rd2   = (r_ext + d_ext) << 1;

  always_comb begin
    bnd_d.vel_start   = r_ext;
    bnd_d.width_start = r_ext + d_ext;
    bnd_d.spare_start = r_ext + (d_ext << 1);
    bnd_d.zdr_start   = rd2;
    bnd_d.rhohv_start = rd2 + r_ext;
    bnd_d.kdp_start   = rd2 + (r_ext << 1);
    bnd_d.phidp_start = rd2 + (r_ext << 1) + r_ext;
    bnd_d.total       = (r_ext << 3) - r_ext + (d_ext << 1);
  end

  assign pos       = first_byte_i ? '0 : pos_q;
  assign in_header = pos < rrpd_pkg::POS_W'(rrpd_pkg::HEADER_BYTES);
  assign p         = rrpd_pkg::BND_W'(pos) - rrpd_pkg::BND_W'(rrpd_pkg::HEADER_BYTES);
  assign in_body   = !in_header && (p < bnd_q.total);

  always_comb begin
    prod     = rrpd_pkg::PROD_REF;
    base     = '0;
    is_phidp = 1'b0;
    emit     = 1'b0;
    if (in_body) begin
      emit = 1'b1;
      if (p < bnd_q.vel_start) begin
        prod = rrpd_pkg::PROD_REF;
      end else if (p < bnd_q.width_start) begin
        prod = rrpd_pkg::PROD_VEL;
        base = bnd_q.vel_start;
      end else if (p < bnd_q.spare_start) begin
        prod = rrpd_pkg::PROD_WIDTH;
        base = bnd_q.width_start;
      end else if (p < bnd_q.zdr_start) begin
        emit = 1'b0;  // unused block after spectrum width
      end else if (p < bnd_q.rhohv_start) begin
        prod = rrpd_pkg::PROD_ZDR;
        base = bnd_q.zdr_start;
      end else if (p < bnd_q.kdp_start) begin
        prod = rrpd_pkg::PROD_RHOHV;
        base = bnd_q.rhohv_start;
      end else if (p < bnd_q.phidp_start) begin
        prod = rrpd_pkg::PROD_KDP;
        base = bnd_q.kdp_start;
      end else begin
        prod     = rrpd_pkg::PROD_PHIDP;
        base     = bnd_q.phidp_start;
        is_phidp = 1'b1;
      end
    end
  end

  assign off = p - base;

  // phidp low byte is held, the high byte completes the word
  always_comb begin
    emit_o = emit;
    if (is_phidp && !off[0]) emit_o = 1'b0;
  end

  assign item_o.prod = prod;
  assign item_o.bin  = is_phidp ? off[rrpd_pkg::BIN_W:1] : off[rrpd_pkg::BIN_W-1:0];
  assign item_o.code = is_phidp ? {data_byte_i, held_q}
                                : rrpd_pkg::CODE_W'(data_byte_i);
  assign item_o.last = (p == bnd_q.total - rrpd_pkg::BND_W'(1));

  always_comb begin
    pos_d  = pos_q;
    held_d = held_q;
    if (accept_i) begin
      pos_d = (pos == '1) ? pos : pos + rrpd_pkg::POS_W'(1);
      if (is_phidp && !off[0]) held_d = data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_bins_q <= '0;
      dpl_bins_q <= '0;
      bnd_q      <= '0;
      pos_q      <= '0;
      held_q     <= '0;
    end else begin
      ref_bins_q <= ref_bins_d;
      dpl_bins_q <= dpl_bins_d;
      bnd_q      <= bnd_d;
      pos_q      <= pos_d;
      held_q     <= held_d;
    end
  end

endmodule

FILE: rtl/rrpd_fifo.sv
// short queue of classified samples between the classifier and the scaler
module rrpd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rrpd_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            not_full_o,
  output logic            not_empty_o,
  output rrpd_pkg::item_t item_o
);

  rrpd_pkg::item_t                   mem_q [rrpd_pkg::FIFO_DEPTH];
  logic [rrpd_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [rrpd_pkg::FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [rrpd_pkg::FIFO_CNT_W-1:0]   count_q, count_d;
  logic                              do_push, do_pop;

  assign not_full_o  = count_q != rrpd_pkg::FIFO_CNT_W'(rrpd_pkg::FIFO_DEPTH);
  assign not_empty_o = count_q != '0;
  assign item_o      = mem_q[rd_ptr_q];

  assign do_push = push_i && not_full_o;
  assign do_pop  = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = wr_ptr_q + rrpd_pkg::FIFO_PTR_W'(1);
    if (do_pop)  rd_ptr_d = rd_ptr_q + rrpd_pkg::FIFO_PTR_W'(1);
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + rrpd_pkg::FIFO_CNT_W'(1);
      2'b01:   count_d = count_q - rrpd_pkg::FIFO_CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/rrpd_back.sv
// back end: range check and fixed point scaling in two stages, output register
module rrpd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         avail_i,
  input  rrpd_pkg::item_t              item_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rrpd_pkg::PROD_W-1:0]  prod_o,
  output logic [rrpd_pkg::BIN_W-1:0]   bin_o,
  output logic [rrpd_pkg::VAL_W-1:0]   val_o,
  output logic                         ok_o,
  output logic                         last_o
);

  logic                         advance;
  logic [rrpd_pkg::BYTE_W-1:0]  c8;
  logic [rrpd_pkg::CODE_W-1:0]  code;

  // stage 1 results
  logic                         ok1;
  logic [rrpd_pkg::VAL_W-1:0]   val1;
  logic [6:0]                   zdr_mag, rho_mag, kdp_mag;
  logic [9:0]                   zdr_y, kdp_y;
  logic [13:0]                  rho_y;
  logic [20:0]                  zdr_t, kdp_t;
  logic [32:0]                  rho_t;
  logic [rrpd_pkg::VAL_W-1:0]   zdr_v, rho_v, kdp_v;
  logic [rrpd_pkg::CODE_W-1:0]  ph_c;
  logic [rrpd_pkg::PH_W-1:0]    ph_y;

  logic                         s1_v_q;
  logic [rrpd_pkg::PROD_W-1:0]  s1_prod_q;
  logic [rrpd_pkg::BIN_W-1:0]   s1_bin_q;
  logic                         s1_last_q, s1_ok_q, s1_top_q;
  logic [rrpd_pkg::VAL_W-1:0]   s1_val_q;
  logic [rrpd_pkg::PH_W-1:0]    s1_ph_q;

  // stage 2: exact division by 2^15-1 through two folds
  logic [rrpd_pkg::PH_Q_W-1:0]  ph_a, ph_q;
  logic [rrpd_pkg::PH_Q_W:0]    ph_s;
  logic [6:0]                   ph_a2;
  logic [rrpd_pkg::PH_LOW_W:0]  ph_r;
  logic [rrpd_pkg::VAL_W-1:0]   val2;

  logic                         out_v_q;
  logic [rrpd_pkg::PROD_W-1:0]  out_prod_q;
  logic [rrpd_pkg::BIN_W-1:0]   out_bin_q;
  logic [rrpd_pkg::VAL_W-1:0]   out_val_q;
  logic                         out_ok_q, out_last_q;

  assign advance = !out_v_q || out_ready_i;
  assign pop_o   = advance && avail_i;

  assign code = item_i.code;
  assign c8   = code[rrpd_pkg::BYTE_W-1:0];

  // round(|k| * scale) = whole part times |k| plus a small rounded remainder
  assign zdr_mag = (c8 < 8'd50) ? 7'(8'd50 - c8) : 7'(c8 - 8'd50);
  assign zdr_y   = 10'(zdr_mag) * 10'd6 + 10'd5;
  assign zdr_t   = 21'(zdr_y) * 21'd205;
  assign zdr_v   = rrpd_pkg::VAL_W'(zdr_mag) * rrpd_pkg::VAL_W'(409)
                 + rrpd_pkg::VAL_W'(zdr_t[20:11]);

  assign rho_mag = 7'(c8 - 8'd5);
  assign rho_y   = 14'(rho_mag) * 14'd96 + 14'd50;
  assign rho_t   = 33'(rho_y) * 33'd5243;
  assign rho_v   = rrpd_pkg::VAL_W'(rho_mag) * rrpd_pkg::VAL_W'(40)
                 + rrpd_pkg::VAL_W'(rho_t[32:19]);

  assign kdp_mag = (c8 < 8'd60) ? 7'(8'd60 - c8) : 7'(c8 - 8'd60);
  assign kdp_y   = 10'(kdp_mag) * 10'd8 + 10'd5;
  assign kdp_t   = 21'(kdp_y) * 21'd205;
  assign kdp_v   = rrpd_pkg::VAL_W'(kdp_mag) * rrpd_pkg::VAL_W'(204)
                 + rrpd_pkg::VAL_W'(kdp_t[20:11]);

  // phidp: (1474560*c + 32767) / 2 = 45*c*2^14 + 16383
  assign ph_c = code - rrpd_pkg::CODE_W'(2);
  assign ph_y = ((rrpd_pkg::PH_W'(ph_c) * rrpd_pkg::PH_W'(45)) << 14)
              + rrpd_pkg::PH_W'(16383);

  always_comb begin
    ok1  = 1'b0;
    val1 = '0;
    case (item_i.prod)
      rrpd_pkg::PROD_REF: begin
        ok1  = c8 >= 8'd2;
        val1 = (rrpd_pkg::VAL_W'(c8) << 11) - rrpd_pkg::VAL_W'(135168);
      end
      rrpd_pkg::PROD_VEL: begin
        ok1  = c8 >= 8'd2;
        val1 = (rrpd_pkg::VAL_W'(c8) << 11) - rrpd_pkg::VAL_W'(264192);
      end
      rrpd_pkg::PROD_WIDTH: begin
        ok1  = c8 >= 8'd129;
        val1 = (rrpd_pkg::VAL_W'(c8) << 11) - rrpd_pkg::VAL_W'(264192);
      end
      rrpd_pkg::PROD_ZDR: begin
        ok1  = (c8 >= 8'd20) && (c8 <= 8'd110);
        val1 = (c8 < 8'd50) ? -zdr_v : zdr_v;
      end
      rrpd_pkg::PROD_RHOHV: begin
        ok1  = (c8 >= 8'd5) && (c8 <= 8'd105);
        val1 = rho_v;
      end
      rrpd_pkg::PROD_KDP: begin
        ok1  = (c8 >= 8'd20) && (c8 <= 8'd160);
        val1 = (c8 < 8'd60) ? -kdp_v : kdp_v;
      end
      rrpd_pkg::PROD_PHIDP: begin
        ok1  = code >= rrpd_pkg::CODE_W'(2);
        val1 = '0;
      end
      default: begin
        ok1  = 1'b0;
        val1 = '0;
      end
    endcase
  end

  assign ph_a  = s1_ph_q[rrpd_pkg::PH_W-1:rrpd_pkg::PH_LOW_W];
  assign ph_s  = (rrpd_pkg::PH_Q_W+1)'(ph_a)
               + (rrpd_pkg::PH_Q_W+1)'(s1_ph_q[rrpd_pkg::PH_LOW_W-1:0]);
  assign ph_a2 = ph_s[rrpd_pkg::PH_Q_W:rrpd_pkg::PH_LOW_W];
  assign ph_r  = (rrpd_pkg::PH_LOW_W+1)'(ph_a2)
               + (rrpd_pkg::PH_LOW_W+1)'(ph_s[rrpd_pkg::PH_LOW_W-1:0]);
  assign ph_q  = ph_a + rrpd_pkg::PH_Q_W'(ph_a2)
               + rrpd_pkg::PH_Q_W'(ph_r >= (rrpd_pkg::PH_LOW_W+1)'(rrpd_pkg::PH_DIV_M));

  always_comb begin
    val2 = s1_val_q;
    if (s1_prod_q == rrpd_pkg::PROD_PHIDP) begin
      val2 = s1_top_q ? rrpd_pkg::PHIDP_TOP_VAL : rrpd_pkg::VAL_W'(ph_q);
    end
    if (!s1_ok_q) val2 = '0;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_prod_q  <= item_i.prod;
      s1_bin_q   <= item_i.bin;
      s1_last_q  <= item_i.last;
      s1_ok_q    <= ok1;
      s1_val_q   <= val1;
      s1_top_q   <= code == rrpd_pkg::PHIDP_TOP_CODE;
      s1_ph_q    <= ph_y;
      out_prod_q <= s1_prod_q;
      out_bin_q  <= s1_bin_q;
      out_val_q  <= val2;
      out_ok_q   <= s1_ok_q;
      out_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q  <= avail_i;
      out_v_q <= s1_v_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign prod_o      = out_prod_q;
  assign bin_o       = out_bin_q;
  assign val_o       = out_val_q;
  assign ok_o        = out_ok_q;
  assign last_o      = out_last_q;

endmodule

FILE: rtl/radar_radial_product_decoder_unit.sv
// top level of the radar radial product decoder
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: data_byte, tuser: first_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: bin_index, scaled_value, is_valid
//                                               tuser: product, tlast: last_of_radial
//  cfg       in   cfg_valid_i/cfg_ready_o       cfg_addr_i: register, cfg_data_i: value
//
// one byte is accepted every cycle while the queue has room; a result passes through
// the queue write, the scaling stage and the output register when nothing stalls.
// the phidp division by 2^15-1 sets the depth of the scaling pipe.
// reset clears bin counts, position and the queue; no clearing pass is needed.
// a stalled output fills the four-entry queue before s_axis_tready drops.
module radar_radial_product_decoder_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] data_byte
  input  logic                               s_axis_tuser,   // [0] first_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [39:0]                        m_axis_tdata,   // [11:0] bin_index,
                                                             // [35:12] scaled_value,
                                                             // [36] is_valid, [39:37] 0
  output logic [rrpd_pkg::PROD_W-1:0]        m_axis_tuser,   // [2:0] product
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rrpd_pkg::ADDR_W-1:0]        cfg_addr_i,
  input  logic [rrpd_pkg::CNT_W-1:0]         cfg_data_i
);

  logic                        accept, emit, fifo_not_full, fifo_not_empty, pop;
  rrpd_pkg::item_t             front_item, head_item;
  logic [rrpd_pkg::BIN_W-1:0]  bin;
  logic [rrpd_pkg::VAL_W-1:0]  val;
  logic                        ok;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = fifo_not_full;
  assign accept        = s_axis_tvalid && fifo_not_full;

  rrpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .data_byte_i  (s_axis_tdata),
    .first_byte_i (s_axis_tuser),
    .emit_o       (emit),
    .item_o       (front_item)
  );

  rrpd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && emit),
    .item_i      (front_item),
    .pop_i       (pop),
    .not_full_o  (fifo_not_full),
    .not_empty_o (fifo_not_empty),
    .item_o      (head_item)
  );

  rrpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (fifo_not_empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .prod_o      (m_axis_tuser),
    .bin_o       (bin),
    .val_o       (val),
    .ok_o        (ok),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, ok, val, bin};

endmodule

FILE: tb/radar_radial_product_decoder_unit_test.sv
// testbench of the radar radial product decoder: byte stream in, scaled samples checked out
module radar_radial_product_decoder_unit_test;
  import rrpd_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_POS       = 65535;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [BIN_W-1:0]  bin;
    logic [VAL_W-1:0]  val;
    logic              ok;
    logic              last;
  } sample_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [39:0]         m_axis_tdata;
  logic [PROD_W-1:0]   m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [ADDR_W-1:0]   cfg_addr_i;
  logic [CNT_W-1:0]    cfg_data_i;

  // decoder state as seen from outside
  logic [CNT_W-1:0]    ref_bins_cfg;
  logic [CNT_W-1:0]    dpl_bins_cfg;
  int                  radial_pos;
  logic [7:0]          phidp_low;
  sample_t             pending_samples[$];

  int send_idle_pct;
  int recv_idle_pct;
  int bytes_sent;
  int radials_sent;
  int samples_predicted;
  int samples_checked;
  int invalid_predicted;
  int mismatches;

  radar_radial_product_decoder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d samples outstanding", pending_samples.size());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int sat_bins(input logic [CNT_W-1:0] n);
    return (n > MAX_BINS) ? MAX_BINS : int'(n);
  endfunction

  function automatic int radial_len();
    return HEADER_BYTES + 7 * sat_bins(ref_bins_cfg) + 2 * sat_bins(dpl_bins_cfg);
  endfunction

  // round half away from zero of k*mul/den
  function automatic int scale_q12(input int k, input longint mul, input longint den);
    longint mag;
    longint q;
    mag = (k < 0) ? longint'(-k) : longint'(k);
    q = (2 * mag * mul + den) / (2 * den);
    return (k < 0) ? int'(-q) : int'(q);
  endfunction

  function automatic void scale_code(input logic [PROD_W-1:0] prod, input logic [15:0] code,
                                     output logic [VAL_W-1:0] val, output logic ok);
    int c;
    int v;
    c = int'(code);
    v = 0;
    ok = 1'b0;
    case (prod)
      PROD_REF: if (c >= 2 && c <= 255) begin
        ok = 1'b1;
        v = c * 2048 - 33 * 4096;
      end
      PROD_VEL: if (c >= 2 && c <= 255) begin
        ok = 1'b1;
        v = c * 2048 - 129 * 2048;
      end
      PROD_WIDTH: if (c >= 129 && c <= 255) begin
        ok = 1'b1;
        v = c * 2048 - 129 * 2048;
      end
      PROD_ZDR: if (c >= 20 && c <= 110) begin
        ok = 1'b1;
        v = scale_q12(c - 50, 4096, 10);
      end
      PROD_RHOHV: if (c >= 5 && c <= 105) begin
        ok = 1'b1;
        v = scale_q12(c - 5, 4096, 100);
      end
      PROD_KDP: if (c >= 20 && c <= 160) begin
        ok = 1'b1;
        v = scale_q12(c - 60, 4096, 20);
      end
      default: begin
        // top code is pinned, codes 0 and 1 are overwritten garbage
        if (c == 65535) begin
          ok = 1'b1;
          v = 1474540;
        end else if (c >= 2) begin
          ok = 1'b1;
          v = scale_q12(c - 2, 360 * 4096, 65534);
        end
      end
    endcase
    val = v[VAL_W-1:0];
  endfunction

  // advance the record position and queue the sample this byte produces, if any
  function automatic void decode_radial_byte(input logic [7:0] b, input logic first);
    int pos;
    int p;
    int r;
    int d;
    int total;
    int bin_no;
    int off;
    logic [15:0] code;
    logic [PROD_W-1:0] prod;
    sample_t s;
    pos = first ? 0 : radial_pos;
    r = sat_bins(ref_bins_cfg);
    d = sat_bins(dpl_bins_cfg);
    total = 7 * r + 2 * d;
    radial_pos = (pos < MAX_POS) ? pos + 1 : MAX_POS;
    if (pos < HEADER_BYTES) return;
    p = pos - HEADER_BYTES;
    if (p >= total) return;
    code = {8'h00, b};
    if (p < r) begin
      prod = PROD_REF;
      bin_no = p;
    end else if (p < r + d) begin
      prod = PROD_VEL;
      bin_no = p - r;
    end else if (p < r + 2 * d) begin
      prod = PROD_WIDTH;
      bin_no = p - r - d;
    end else if (p < 2 * r + 2 * d) begin
      return;
    end else if (p < 3 * r + 2 * d) begin
      prod = PROD_ZDR;
      bin_no = p - 2 * r - 2 * d;
    end else if (p < 4 * r + 2 * d) begin
      prod = PROD_RHOHV;
      bin_no = p - 3 * r - 2 * d;
    end else if (p < 5 * r + 2 * d) begin
      prod = PROD_KDP;
      bin_no = p - 4 * r - 2 * d;
    end else begin
      off = p - 5 * r - 2 * d;
      if ((off % 2) == 0) begin
        phidp_low = b;
        return;
      end
      prod = PROD_PHIDP;
      bin_no = off / 2;
      code = {b, phidp_low};
    end
    s.prod = prod;
    s.bin = bin_no[BIN_W-1:0];
    scale_code(prod, code, s.val, s.ok);
    s.last = (p + 1 == total);
    pending_samples.push_back(s);
    samples_predicted++;
    if (!s.ok) invalid_predicted++;
  endfunction

  function automatic void check_sample();
    sample_t got;
    sample_t want;
    got.prod = m_axis_tuser;
    got.bin = m_axis_tdata[11:0];
    got.val = m_axis_tdata[35:12];
    got.ok = m_axis_tdata[36];
    got.last = m_axis_tlast;
    samples_checked++;
    if (pending_samples.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected sample: prod %0d bin %0d val %0d ok %0b last %0b",
                 got.prod, got.bin, $signed(got.val), got.ok, got.last);
    end else begin
      want = pending_samples.pop_front();
      if (got !== want || m_axis_tdata[39:37] !== 3'b000) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected prod %0d bin %0d val %0d ok %0b last %0b",
                   want.prod, want.bin, $signed(want.val), want.ok, want.last);
          $display("          got prod %0d bin %0d val %0d ok %0b last %0b pad %0b",
                   got.prod, got.bin, $signed(got.val), got.ok, got.last,
                   m_axis_tdata[39:37]);
        end
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_sample();
  end

  initial begin
    m_axis_tready = 1'b0;
    forever @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic first);
    @(negedge clk_i);
    // idle cycle by cycle with the sender's idle share
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    if (first) radials_sent++;
    decode_radial_byte(b, first);
  endtask

  // hold the stream off until every queued sample has come out
  task automatic drain_samples();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CNT_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_REF_BINS) ref_bins_cfg = value;
    else dpl_bins_cfg = value;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_bins(input logic [CNT_W-1:0] r, input logic [CNT_W-1:0] d);
    drain_samples();
    write_reg(REG_REF_BINS, r);
    write_reg(REG_DPL_BINS, d);
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(1) == 0) return 8'($urandom_range(255));
    case ($urandom_range(7))
      0: return 8'($urandom_range(0, 6));
      1: return 8'($urandom_range(18, 22));
      2: return 8'($urandom_range(103, 112));
      3: return 8'($urandom_range(126, 131));
      4: return 8'($urandom_range(158, 162));
      5: return 8'($urandom_range(250, 255));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one record of len bytes with random content, then extra bytes past its end
  task automatic send_radial(input int len, input int extra);
    for (int i = 0; i < len + extra; i++) begin
      if (i > 0 && $urandom_range(499) == 0) drain_samples();
      send_byte(pick_byte(), i == 0);
    end
  endtask

  task automatic send_coded_radial(input logic [7:0] body[$], input int extra);
    for (int i = 0; i < HEADER_BYTES; i++) send_byte((i % 2) ? 8'h5A : 8'hA5, i == 0);
    foreach (body[i]) begin
      if (i == 9) drain_samples();
      send_byte(body[i], 1'b0);
    end
    for (int i = 0; i < extra; i++) send_byte(8'hFF, 1'b0);
  endtask

  // range edges of every product, phidp 0, 1, 2 and the top code
  task automatic test_code_ranges();
    set_bins(13'd2, 13'd2);
    send_coded_radial({8'd1, 8'd2, 8'd0, 8'd255, 8'd128, 8'd129, 8'h00, 8'hFF,
                       8'd19, 8'd110, 8'd4, 8'd105, 8'd20, 8'd161,
                       8'h01, 8'h00, 8'hFF, 8'hFF}, 2);
    send_coded_radial({8'd0, 8'd255, 8'd1, 8'd2, 8'd255, 8'd254, 8'hFF, 8'h00,
                       8'd20, 8'd111, 8'd5, 8'd106, 8'd19, 8'd160,
                       8'h00, 8'h00, 8'h02, 8'h00}, 0);
  endtask

  // empty record, records with only one group of products and one with a single bin of each
  task automatic test_bin_count_edges();
    set_bins(13'd0, 13'd0);
    send_radial(HEADER_BYTES + 12, 0);
    set_bins(13'd0, 13'd3);
    send_radial(radial_len(), 3);
    set_bins(13'd3, 13'd0);
    send_radial(radial_len(), 3);
    set_bins(13'd1, 13'd1);
    send_radial(radial_len(), 1);
  endtask

  task automatic test_random_radials(input int target);
    int goal;
    int kind;
    int len;
    logic [CNT_W-1:0] r;
    logic [CNT_W-1:0] d;
    goal = samples_predicted + target;
    while (samples_predicted < goal) begin
      if ($urandom_range(3) == 0) begin
        r = ($urandom_range(7) == 0) ? CNT_W'($urandom_range(13, 80)) : CNT_W'($urandom_range(12));
        d = ($urandom_range(7) == 0) ? CNT_W'($urandom_range(13, 80)) : CNT_W'($urandom_range(12));
        set_bins(r, d);
      end
      kind = $urandom_range(99);
      len = radial_len();
      if (kind < 75) begin
        send_radial(len, $urandom_range(3));
      end else if (kind < 90) begin
        // record cut short by the next one
        send_radial($urandom_range(1, len), 0);
      end else begin
        for (int i = 0; i < $urandom_range(1, 40); i++)
          send_byte(pick_byte(), $urandom_range(15) == 0);
      end
    end
  endtask

  // saturated bin counts at the start of a long record, then a short one
  task automatic test_large_radial();
    set_bins(13'h1FFF, 13'h1FFF);
    send_radial(HEADER_BYTES + 60, 0);
    set_bins(CNT_W'(MAX_BINS), CNT_W'(MAX_BINS));
    send_radial(HEADER_BYTES + 60, 0);
    set_bins(13'd3, 13'd2);
    send_radial(radial_len(), 2);
  endtask

  task automatic finish_stream();
    int waited;
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_samples.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    if (pending_samples.size() != 0) begin
      mismatches += pending_samples.size();
      $display("%0d expected samples never came out", pending_samples.size());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = '0;
    cfg_data_i = '0;
    ref_bins_cfg = '0;
    dpl_bins_cfg = '0;
    radial_pos = 0;
    phidp_low = '0;
    bytes_sent = 0;
    radials_sent = 0;
    samples_predicted = 0;
    samples_checked = 0;
    invalid_predicted = 0;
    mismatches = 0;
    send_idle_pct = 7;
    recv_idle_pct = 72;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_code_ranges();
    test_bin_count_edges();
    test_random_radials(60);
    send_idle_pct = 72;
    recv_idle_pct = 7;
    test_random_radials(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_radials(60);
    test_large_radial();
    finish_stream();

    $display("sent %0d bytes in %0d records, checked %0d samples (%0d with invalid codes)",
             bytes_sent, radials_sent, samples_checked, invalid_predicted);
    $display("bin counts from empty to saturated, code range edges, stalls on either side");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rrpd_pkg.sv
rtl/rrpd_front.sv
rtl/rrpd_fifo.sv
rtl/rrpd_back.sv
rtl/radar_radial_product_decoder_unit.sv
tb/radar_radial_product_decoder_unit_test.sv
